// ===== hw/rtl/stt_pkg.sv =====
// Shared types and constants for the sleep timeout table.
// Holds the item structs, the function codes, and the controller/datapath interface types.
// No dependencies.
package stt_pkg;

    localparam int SLOTS     = 32;
    localparam int ID_BITS   = 16;
    localparam int WAITER_W  = 16;
    localparam int COUNT_W   = 31;
    localparam int ELAPSED_W = 9;

    // Stored identifier width: identifiers are masked to ID_BITS.
    localparam int ID_W      = (ID_BITS < WAITER_W) ? ID_BITS : WAITER_W;
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_BITS  = $clog2(SLOTS + 1);

    localparam logic [1:0] FUNC_JOIN  = 2'd0;
    localparam logic [1:0] FUNC_LEAVE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic [WAITER_W-1:0]  waiter_id;
        logic [COUNT_W-1:0]   sleep_count;
        logic [ELAPSED_W-1:0] elapsed;
    } stt_in_t;

    typedef struct packed {
        logic                fired;
        logic [WAITER_W-1:0] fired_id;
        logic                status;
        logic                last;
    } stt_out_t;

    typedef struct packed {
        logic [ID_W-1:0]    waiter;
        logic [COUNT_W-1:0] remain;
    } stt_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } stt_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_KEEP,
        OP_SKIP,
        OP_UPDATE,
        OP_APPEND,
        OP_REFUSE,
        OP_COMMIT,
        OP_FIRE,
        OP_FINISH
    } stt_op_t;

    typedef struct packed {
        logic       scan_done;
        logic       hit;
        logic       expire;
        logic       full;
        logic       pend_valid;
        logic       out_free;
        logic [1:0] func;
    } stt_status_t;

endpackage

// ===== hw/rtl/stt_datapath.sv =====
// Datapath of the sleep timeout table: entry memory, scan pointers and output register.
// Depends on stt_pkg; driven one operation per cycle by stt_ctrl.
module stt_datapath
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  stt_op_t     op,
    output stt_status_t status,
    input  stt_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output stt_out_t    out_data
);

    stt_entry_t slot_mem_reg [SLOTS];
    stt_entry_t rdata_reg;

    logic [1:0]           func_reg,       func_next;
    logic [ID_W-1:0]      id_reg,         id_next;
    logic [COUNT_W-1:0]   count_reg,      count_next;
    logic [ELAPSED_W-1:0] elapsed_reg,    elapsed_next;
    logic [CNT_BITS-1:0]  rd_reg,         rd_next;
    logic [CNT_BITS-1:0]  wr_reg,         wr_next;
    logic [CNT_BITS-1:0]  total_reg,      total_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]      pend_id_reg,    pend_id_next;
    logic                 refuse_reg,     refuse_next;
    logic                 out_valid_reg,  out_valid_next;
    stt_out_t             out_data_reg,   out_data_next;

    logic                 mem_we;
    logic [SLOT_BITS-1:0] mem_waddr;
    stt_entry_t           mem_wdata;
    logic [COUNT_W-1:0]   elapsed_ext;
    logic                 out_free;
    logic                 push;
    stt_out_t             push_data;

    assign elapsed_ext = COUNT_W'(elapsed_reg);
    assign out_free    = !out_valid_reg || out_ready;

    assign status.scan_done  = (rd_reg == total_reg) ||
                               ((func_reg != FUNC_JOIN) && (func_reg != FUNC_LEAVE) &&
                                (func_reg != FUNC_TICK));
    assign status.hit        = (rdata_reg.waiter == id_reg);
    assign status.expire     = (rdata_reg.remain < elapsed_ext);
    assign status.full       = (total_reg == CNT_BITS'(SLOTS));
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;
    assign status.func       = func_reg;

    // Memory write port: compaction, in-place update or append.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_reg[SLOT_BITS-1:0];
        mem_wdata = rdata_reg;
        case (op)
            OP_KEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr_reg[SLOT_BITS-1:0];
                if (func_reg == FUNC_TICK)
                begin
                    mem_wdata.remain = rdata_reg.remain - elapsed_ext;
                end
            end
            OP_UPDATE:
            begin
                mem_we    = 1'b1;
                mem_waddr = rd_reg[SLOT_BITS-1:0];
                mem_wdata = '{waiter: id_reg, remain: count_reg};
            end
            OP_APPEND:
            begin
                mem_we    = 1'b1;
                mem_waddr = total_reg[SLOT_BITS-1:0];
                mem_wdata = '{waiter: id_reg, remain: count_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem_reg[mem_waddr] <= mem_wdata;
        end
        if (op == OP_READ)
        begin
            rdata_reg <= slot_mem_reg[rd_reg[SLOT_BITS-1:0]];
        end
    end

    always_comb
    begin
        func_next       = func_reg;
        id_next         = id_reg;
        count_next      = count_reg;
        elapsed_next    = elapsed_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        total_next      = total_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        refuse_next     = refuse_reg;
        push            = 1'b0;
        push_data       = '{fired: 1'b1, fired_id: WAITER_W'(pend_id_reg),
                            status: 1'b0, last: 1'b0};
        case (op)
            OP_LOAD:
            begin
                func_next       = in_data.func;
                id_next         = in_data.waiter_id[ID_W-1:0];
                count_next      = in_data.sleep_count;
                elapsed_next    = in_data.elapsed;
                rd_next         = '0;
                wr_next         = '0;
                pend_valid_next = 1'b0;
                refuse_next     = 1'b0;
            end
            OP_KEEP:
            begin
                rd_next = rd_reg + CNT_BITS'(1);
                wr_next = wr_reg + CNT_BITS'(1);
            end
            OP_SKIP:
            begin
                rd_next = rd_reg + CNT_BITS'(1);
            end
            OP_FIRE:
            begin
                // Release the previous expiry as a non-final result, hold the new one.
                rd_next         = rd_reg + CNT_BITS'(1);
                push            = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_id_next    = rdata_reg.waiter;
            end
            OP_APPEND:
            begin
                total_next = total_reg + CNT_BITS'(1);
            end
            OP_REFUSE:
            begin
                refuse_next = 1'b1;
            end
            OP_COMMIT:
            begin
                total_next = wr_reg;
            end
            OP_FINISH:
            begin
                push      = 1'b1;
                push_data = '{fired: pend_valid_reg,
                              fired_id: pend_valid_reg ? WAITER_W'(pend_id_reg) : '0,
                              status: refuse_reg, last: 1'b1};
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = push_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg         <= '0;
            wr_reg         <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            refuse_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            func_reg       <= FUNC_JOIN;
        end
        else
        begin
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            refuse_reg     <= refuse_next;
            out_valid_reg  <= out_valid_next;
            func_reg       <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        count_reg    <= count_next;
        elapsed_reg  <= elapsed_next;
        pend_id_reg  <= pend_id_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/stt_ctrl.sv =====
// Controller of the sleep timeout table: sequences reads, evaluations and results.
// Depends on stt_pkg; commands stt_datapath through one operation code per cycle.
module stt_ctrl
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  stt_status_t status,
    output stt_op_t     op
);

    stt_state_t state_reg, state_next;
    logic       fire_stall;

    // Hold on a second expiry until the pending one can go out.
    assign fire_stall = status.expire && status.pend_valid && !status.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = status.scan_done ? ST_DONE : ST_EVAL;
            end
            ST_EVAL:
            begin
                case (status.func)
                    FUNC_JOIN:  state_next = status.hit ? ST_DONE : ST_READ;
                    FUNC_LEAVE: state_next = ST_READ;
                    FUNC_TICK:  state_next = fire_stall ? ST_EVAL : ST_READ;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        op       = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = OP_LOAD;
                end
            end
            ST_READ:
            begin
                if (status.scan_done)
                begin
                    case (status.func)
                        FUNC_JOIN:  op = status.full ? OP_REFUSE : OP_APPEND;
                        FUNC_LEAVE: op = OP_COMMIT;
                        FUNC_TICK:  op = OP_COMMIT;
                        default:    op = OP_NONE;
                    endcase
                end
                else
                begin
                    op = OP_READ;
                end
            end
            ST_EVAL:
            begin
                case (status.func)
                    FUNC_JOIN:  op = status.hit ? OP_UPDATE : OP_SKIP;
                    FUNC_LEAVE: op = status.hit ? OP_SKIP : OP_KEEP;
                    FUNC_TICK:
                    begin
                        if (!status.expire)
                        begin
                            op = OP_KEEP;
                        end
                        else if (!fire_stall)
                        begin
                            op = OP_FIRE;
                        end
                    end
                    default:    op = OP_NONE;
                endcase
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    op = OP_FINISH;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/sleep_timeout_table.sv =====
// Top level of the sleep timeout table: a packed table of waiters with tick countdown.
// Depends on stt_pkg, stt_ctrl and stt_datapath.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | in        | in_valid / in_ready   | stt_in_t: func, waiter_id, sleep_count,
//           |           |                       |           elapsed
//   out     | out       | out_valid / out_ready | stt_out_t: fired, fired_id, status, last
//
// Scan: each item is accepted in ST_IDLE, then each held entry is read in ST_READ and
// evaluated in ST_EVAL, and the item ends in ST_DONE. A join that finds its waiter stops
// early, and the unused function code skips the scan. The entry memory has one
// registered read port, so each slot passes through a read state and an evaluate state.
// Reset: rst_n clears the entry count, the controller and the output valid flag; the entry
// memory itself is not cleared, the count alone marks which slots hold waiters.
// Stalls: a finished result waits in the output register while the next item is taken.
// The final result of every item holds the controller until the output register is free,
// and a tick also holds when a second expiry is found before the first has left.
//
// The entries stay packed in join order. Leave and tick rewrite the table in one pass
// with a read pointer and a trailing write pointer, dropping removed entries. An expired
// waiter is held back one step, so the final one can carry the last flag.
module sleep_timeout_table
    import stt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  stt_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output stt_out_t out_data
);

    stt_op_t     op;
    stt_status_t status;

    // Sequence the scan and the result.
    stt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    // Hold the table, the scan pointers and the output register.
    stt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
